### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. The bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/abc_pkg.sv
package abc_pkg;

    // Command codes.
    localparam logic [1:0] CMD_POST    = 2'd0;
    localparam logic [1:0] CMD_RX_POST = 2'd1;
    localparam logic [1:0] CMD_PROCESS = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_SIZE_BAD    = 2'd1;
    localparam logic [1:0] ST_NO_BUFFER   = 2'd2;
    localparam logic [1:0] ST_RX_SIZE_BAD = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [1:0] REG_SEQ_FIRST     = 2'd2;
    localparam logic [1:0] REG_SEQ_SECOND    = 2'd3;

    // Reset values.
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd255;
    localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd400;
    localparam logic [7:0]  RST_SEQ_FIRST     = 8'd1;
    localparam logic [7:0]  RST_SEQ_SECOND    = 8'd2;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] payload_size;
        logic        rx_size_ok;
        logic [7:0]  rx_seq;
        logic [7:0]  partner_ack_seq;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0] status;
        logic       tx_start;
        logic [7:0] tx_seq_stamp;
        logic       rx_deliver;
        logic [7:0] rx_ack_seq;
        logic       tx_acked;
        logic       tx_timed_out;
        logic       tx_busy;
    } t_result_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_word;

    typedef struct packed {
        logic [15:0] max_payload;
        logic [15:0] timeout_limit;
        logic [7:0]  seq_first;
        logic [7:0]  seq_second;
    } t_cfg;

endpackage

### rtl/abc_stream_if.sv
interface abc_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/alternating_bit_channel_core.sv
// Alternating-bit channel control core. Commands arrive on i_cmd (post, receive buffer
// posted, process) and each one yields exactly one result word on o_res, in order.
// A command is taken in every cycle that the result side keeps up. It is held in an input
// register at the accepting edge and moves on into the result register, which presents its
// result on o_res, as soon as the result register is free.
// A stalled result side stops new commands only once both registers are full.
// Configuration writes on i_cfg are always taken and must be made while the channel is idle.
module alternating_bit_channel_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    abc_stream_if.sink   i_cfg,
    abc_stream_if.sink   i_cmd,
    abc_stream_if.source o_res
);
    import abc_pkg::*;

    t_cfg w_cfg;

    abc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    abc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );
endmodule

### rtl/abc_cfg_regs.sv
module abc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    abc_stream_if.sink     i_cfg,
    output abc_pkg::t_cfg  o_cfg
);
    import abc_pkg::*;

    t_cfg r_cfg;

    // Writes are taken in every cycle.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_payload   <= RST_MAX_PAYLOAD;
            r_cfg.timeout_limit <= RST_TIMEOUT_LIMIT;
            r_cfg.seq_first     <= RST_SEQ_FIRST;
            r_cfg.seq_second    <= RST_SEQ_SECOND;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                REG_MAX_PAYLOAD:   r_cfg.max_payload   <= i_cfg.payload.data;
                REG_TIMEOUT_LIMIT: r_cfg.timeout_limit <= i_cfg.payload.data;
                REG_SEQ_FIRST:     r_cfg.seq_first     <= i_cfg.payload.data[7:0];
                REG_SEQ_SECOND:    r_cfg.seq_second    <= i_cfg.payload.data[7:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end
endmodule

### rtl/abc_core.sv
module abc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abc_pkg::t_cfg  i_cfg,
    abc_stream_if.sink     i_cmd,
    abc_stream_if.source   o_res
);
    import abc_pkg::*;
`include "assert_macros.svh"

    // Input register.
    logic         r_in_valid;
    t_cmd_word    r_in;
    // Result register.
    logic         r_out_valid;
    t_result_word r_out;
    // Channel state.
    logic         r_tx_lock;
    logic [7:0]   r_tx_seq;
    logic [7:0]   r_rx_seq_last;
    logic         r_rx_pending;
    logic         r_timer_running;
    logic [15:0]  r_timer_count;

    logic         n_tx_lock;
    logic [7:0]   n_tx_seq;
    logic [7:0]   n_rx_seq_last;
    logic         n_rx_pending;
    logic         n_timer_running;
    logic [15:0]  n_timer_count;
    t_result_word n_out;

    logic         w_out_free;
    logic         w_advance;
    logic [7:0]   w_seq_toggled;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_cmd.ready = !r_in_valid || w_out_free;
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    assign w_seq_toggled = (r_tx_seq == i_cfg.seq_first) ? i_cfg.seq_second : i_cfg.seq_first;

    always_comb begin
        n_tx_lock       = r_tx_lock;
        n_tx_seq        = r_tx_seq;
        n_rx_seq_last   = r_rx_seq_last;
        n_rx_pending    = r_rx_pending;
        n_timer_running = r_timer_running;
        n_timer_count   = r_timer_count;
        n_out           = '0;

        case (r_in.cmd)
            CMD_POST: begin
                if (r_in.payload_size == 16'd0 || r_in.payload_size > i_cfg.max_payload) begin
                    n_out.status = ST_SIZE_BAD;
                end else if (r_tx_lock) begin
                    n_out.status = ST_NO_BUFFER;
                end else begin
                    n_tx_lock          = 1'b1;
                    n_out.tx_seq_stamp = r_tx_seq;
                    n_out.tx_start     = 1'b1;
                    n_timer_running    = 1'b1;
                    n_timer_count      = 16'd0;
                end
            end
            CMD_RX_POST: begin
                if (r_timer_running && r_timer_count != TIMER_MAX) begin
                    n_timer_count = r_timer_count + 16'd1;
                end
                if (!r_in.rx_size_ok) begin
                    n_out.status = ST_RX_SIZE_BAD;
                end else if ((r_in.rx_seq == i_cfg.seq_first || r_in.rx_seq == i_cfg.seq_second)
                             && r_in.rx_seq != r_rx_seq_last) begin
                    n_rx_pending  = 1'b1;
                    n_rx_seq_last = r_in.rx_seq;
                end
            end
            CMD_PROCESS: begin
                if (r_rx_pending) begin
                    n_out.rx_deliver = 1'b1;
                    n_out.rx_ack_seq = r_rx_seq_last;
                    n_rx_pending     = 1'b0;
                end
                if (r_tx_lock) begin
                    if (r_in.partner_ack_seq == r_tx_seq) begin
                        n_tx_lock       = 1'b0;
                        n_tx_seq        = w_seq_toggled;
                        n_timer_running = 1'b0;
                        n_out.tx_acked  = 1'b1;
                    end else if (r_timer_running && r_timer_count >= i_cfg.timeout_limit) begin
                        n_tx_lock          = 1'b0;
                        n_tx_seq           = w_seq_toggled;
                        n_timer_running    = 1'b0;
                        n_out.tx_timed_out = 1'b1;
                    end
                end
            end
            default: begin
                // The unused command only reports the lock.
            end
        endcase

        n_out.tx_busy = n_tx_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_tx_lock       <= 1'b0;
            r_tx_seq        <= RST_SEQ_FIRST;
            r_rx_seq_last   <= 8'd0;
            r_rx_pending    <= 1'b0;
            r_timer_running <= 1'b0;
            r_timer_count   <= 16'd0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance) begin
                r_tx_lock       <= n_tx_lock;
                r_tx_seq        <= n_tx_seq;
                r_rx_seq_last   <= n_rx_seq_last;
                r_rx_pending    <= n_rx_pending;
                r_timer_running <= n_timer_running;
                r_timer_count   <= n_timer_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.payload;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // The timer runs exactly while the transmit buffer is locked.
    `ASSERT_ALWAYS(a_timer_tracks_lock, i_clk, i_rst_n, r_timer_running == r_tx_lock, "timer and lock disagree")
    // A word cannot both be acknowledged and time out.
    `ASSERT_NEVER(a_ack_or_timeout, i_clk, i_rst_n, r_out_valid && r_out.tx_acked && r_out.tx_timed_out, "ack and timeout together")
    // A started transmission leaves the buffer locked.
    `ASSERT_ALWAYS(a_start_locks, i_clk, i_rst_n, (r_out_valid && r_out.tx_start) |-> r_out.tx_busy, "start without lock")
    // Channel state moves only when a word passes into the result register.
    `ASSERT_ALWAYS(a_state_holds, i_clk, i_rst_n, !w_advance |=> ($stable(r_tx_seq) && $stable(r_tx_lock) && $stable(r_rx_pending)), "state changed without a word")
endmodule
